// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tae_pkg.sv =====
// ----------------------------------------------------------------------------
// tae_pkg
// Types, widths and the arctangent table of the azimuth/elevation pipeline.
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int CordicSteps  = 16;
    localparam int DiffW        = 33;
    localparam int SumW         = 66;
    localparam int HypW         = 33;
    localparam int RemW         = 35;
    localparam int SqrtIters    = 33;
    localparam int SqrtPerStage = 2;
    localparam int SqrtStages   = (SqrtIters + SqrtPerStage - 1) / SqrtPerStage;
    localparam int CordW        = 64;
    localparam int AngW         = 34;
    localparam int PaddrW       = 3;

    localparam logic signed [AngW-1:0] HalfPi = 34'sh0_4000_0000;

    localparam logic [31:0] AtanTab [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic signed [31:0] radar_x;
        logic signed [31:0] radar_y;
        logic signed [31:0] radar_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic               last_in_set;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] elevation;
        logic signed [15:0] azimuth;
        logic               last_out;
    } t_out_beat;

    typedef struct packed {
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic signed [DiffW-1:0] dz;
        logic                    last;
    } t_vec;

    function automatic logic signed [AngW-1:0] atan_ang(input int i);
        return signed'({2'b00, AtanTab[i]});
    endfunction

endpackage

// ===== rtl/core/target_azimuth_elevation.sv =====
// ----------------------------------------------------------------------------
// target_azimuth_elevation
// Pointing angles of a target relative to a radar, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while results are taken; every stage has
// its own valid bit and advances whenever it is empty or the next one moves.
// The 17 square-root stages (two root bits each, one in the last) and the
// CORDIC stages set the depth. Synchronous active-low reset empties the
// pipeline and clears plane_mode to the XY plane.
// ----------------------------------------------------------------------------
module target_azimuth_elevation
    import tae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_beat          i_in_beat,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_beat         o_out_beat,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

`include "assert_macros.svh"

    // register index is the word address: paddr[2]
    localparam logic RegPlaneMode = 1'b0;

    logic r_plane;
    logic w_cfg_wr;

    // ---- configuration: one register, written in the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == RegPlaneMode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= 1'b0;
        end else if (w_cfg_wr) begin
            r_plane <= pwdata[0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            RegPlaneMode: prdata = {31'b0, r_plane};
            default:      prdata = '0;
        endcase
    end

    // ---- datapath: squares -> square root -> twin CORDIC
    logic            w_sq_valid, w_sq_ready;
    t_vec            w_sq_vec;
    logic [SumW-1:0] w_sq_sum;
    logic            w_rt_valid, w_rt_ready;
    t_vec            w_rt_vec;
    logic [HypW-1:0] w_rt_hyp;

    // difference vector and dx^2 + dy^2
    tae_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (i_in_beat),
        .o_valid (w_sq_valid),
        .i_ready (w_sq_ready),
        .o_vec   (w_sq_vec),
        .o_sum   (w_sq_sum)
    );

    // floor square root gives the horizontal range h
    tae_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_sq_ready),
        .i_vec   (w_sq_vec),
        .i_sum   (w_sq_sum),
        .o_valid (w_rt_valid),
        .i_ready (w_rt_ready),
        .o_vec   (w_rt_vec),
        .o_hyp   (w_rt_hyp)
    );

    // elevation = atan2(dz, h); azimuth by plane_mode; last flag rides along
    tae_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plane (r_plane),
        .i_valid (w_rt_valid),
        .o_ready (w_rt_ready),
        .i_vec   (w_rt_vec),
        .i_hyp   (w_rt_hyp),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

    // ---- checks
    `AST_SAME(a_el_range, i_clk, i_rst_n, o_out_valid, (o_out_beat.elevation <= 16'sd16384) && (o_out_beat.elevation >= -16'sd16384), "elevation beyond a quarter turn")
    `AST_SAME(a_backpressure, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input blocked without a stalled result")
    `AST_NEXT(a_cfg_write, i_clk, i_rst_n, w_cfg_wr, r_plane == $past(pwdata[0]), "plane_mode write lost")

endmodule

// ===== rtl/core/tae_sqsum.sv =====
// ----------------------------------------------------------------------------
// tae_sqsum
// Difference vector and horizontal sum of squares, four register stages.
// ----------------------------------------------------------------------------
module tae_sqsum
    import tae_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_in_beat        i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output t_vec            o_vec,
    output logic [SumW-1:0] o_sum
);

    logic [3:0] r_v;
    logic [3:0] w_adv;

    t_vec r_a_vec, r_b_vec, r_c_vec, r_d_vec;
    logic [33:0] r_b_hh_x, r_b_hh_y;
    logic [32:0] r_b_hl_x, r_b_hl_y;
    logic [31:0] r_b_ll_x, r_b_ll_y;
    logic [SumW-1:0] r_c_sq_x, r_c_sq_y, r_d_sum;
    logic [DiffW-1:0] w_mx, w_my;

    assign w_adv[3] = !r_v[3] || i_ready;
    assign w_adv[2] = !r_v[2] || w_adv[3];
    assign w_adv[1] = !r_v[1] || w_adv[2];
    assign w_adv[0] = !r_v[0] || w_adv[1];
    assign o_ready  = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
            if (w_adv[3]) r_v[3] <= r_v[2];
        end
    end

    assign w_mx = r_a_vec.dx[DiffW-1] ? DiffW'(-r_a_vec.dx) : DiffW'(r_a_vec.dx);
    assign w_my = r_a_vec.dy[DiffW-1] ? DiffW'(-r_a_vec.dy) : DiffW'(r_a_vec.dy);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_vec.dx   <= {i_beat.target_x[31], i_beat.target_x}
                          - {i_beat.radar_x[31], i_beat.radar_x};
            r_a_vec.dy   <= {i_beat.target_y[31], i_beat.target_y}
                          - {i_beat.radar_y[31], i_beat.radar_y};
            r_a_vec.dz   <= {i_beat.target_z[31], i_beat.target_z}
                          - {i_beat.radar_z[31], i_beat.radar_z};
            r_a_vec.last <= i_beat.last_in_set;
        end
        // split each magnitude into a 17-bit high and 16-bit low half
        if (w_adv[1]) begin
            r_b_vec  <= r_a_vec;
            r_b_hh_x <= w_mx[32:16] * w_mx[32:16];
            r_b_hl_x <= w_mx[32:16] * w_mx[15:0];
            r_b_ll_x <= w_mx[15:0] * w_mx[15:0];
            r_b_hh_y <= w_my[32:16] * w_my[32:16];
            r_b_hl_y <= w_my[32:16] * w_my[15:0];
            r_b_ll_y <= w_my[15:0] * w_my[15:0];
        end
        if (w_adv[2]) begin
            r_c_vec  <= r_b_vec;
            r_c_sq_x <= {r_b_hh_x, 32'b0} + SumW'({r_b_hl_x, 17'b0}) + SumW'(r_b_ll_x);
            r_c_sq_y <= {r_b_hh_y, 32'b0} + SumW'({r_b_hl_y, 17'b0}) + SumW'(r_b_ll_y);
        end
        if (w_adv[3]) begin
            r_d_vec <= r_c_vec;
            r_d_sum <= r_c_sq_x + r_c_sq_y;
        end
    end

    assign o_valid = r_v[3];
    assign o_vec   = r_d_vec;
    assign o_sum   = r_d_sum;

endmodule

// ===== rtl/core/tae_isqrt.sv =====
// ----------------------------------------------------------------------------
// tae_isqrt
// Pipelined restoring integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module tae_isqrt
    import tae_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_vec            i_vec,
    input  logic [SumW-1:0] i_sum,
    output logic            o_valid,
    input  logic            i_ready,
    output t_vec            o_vec,
    output logic [HypW-1:0] o_hyp
);

    typedef struct packed {
        logic [SumW-1:0] rad;
        logic [RemW-1:0] rem;
        logic [HypW-1:0] root;
        t_vec            vec;
    } t_sq_stage;

    t_sq_stage w_st [SqrtStages+1];
    logic      w_v  [SqrtStages+1];
    logic      w_adv[SqrtStages+1];

    assign w_st[0]  = '{rad: i_sum, rem: '0, root: '0, vec: i_vec};
    assign w_v[0]   = i_valid;
    assign w_adv[SqrtStages] = i_ready;
    assign o_ready  = w_adv[0];

    for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
        t_sq_stage r_st;
        logic      r_v;
        t_sq_stage n_st;

        always_comb begin
            logic [RemW:0] t_rem;
            logic [RemW:0] t_trial;
            n_st  = w_st[s];
            t_rem = {1'b0, w_st[s].rem};
            for (int j = 0; j < SqrtPerStage; j++) begin
                if (s * SqrtPerStage + j < SqrtIters) begin
                    t_rem    = {t_rem[RemW-2:0], n_st.rad[SumW-1:SumW-2]};
                    n_st.rad = {n_st.rad[SumW-3:0], 2'b00};
                    t_trial  = {1'b0, n_st.root, 2'b01};
                    if (t_rem >= t_trial) begin
                        t_rem     = t_rem - t_trial;
                        n_st.root = {n_st.root[HypW-2:0], 1'b1};
                    end else begin
                        n_st.root = {n_st.root[HypW-2:0], 1'b0};
                    end
                end
            end
            n_st.rem = t_rem[RemW-1:0];
        end

        assign w_adv[s] = !r_v || w_adv[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_adv[s]) begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[s]) r_st <= n_st;
        end

        assign w_st[s+1] = r_st;
        assign w_v[s+1]  = r_v;
    end

    assign o_valid = w_v[SqrtStages];
    assign o_vec   = w_st[SqrtStages].vec;
    assign o_hyp   = w_st[SqrtStages].root;

endmodule

// ===== rtl/core/tae_cordic.sv =====
// ----------------------------------------------------------------------------
// tae_cordic
// Two-lane vectoring CORDIC: elevation and azimuth, one step per stage.
// ----------------------------------------------------------------------------
module tae_cordic
    import tae_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_plane,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_vec            i_vec,
    input  logic [HypW-1:0] i_hyp,
    output logic            o_valid,
    input  logic            i_ready,
    output t_out_beat       o_beat
);

    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic signed [AngW-1:0]  z;
    } t_lane;

    typedef struct packed {
        t_lane [1:0] ln;
        logic  [1:0] zero;
        logic        last;
    } t_cstage;

    function automatic t_lane prerot(input logic signed [CordW-1:0] y0,
                                     input logic signed [CordW-1:0] x0);
        t_lane r;
        logic signed [CordW-1:0] xs;
        logic signed [CordW-1:0] ys;
        xs  = x0 <<< 24;
        ys  = y0 <<< 24;
        r.x = xs;
        r.y = ys;
        r.z = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                r.x = ys;
                r.y = -xs;
                r.z = HalfPi;
            end else begin
                r.x = -ys;
                r.y = xs;
                r.z = -HalfPi;
            end
        end
        return r;
    endfunction

    function automatic t_lane cstep(input t_lane a, input int i);
        t_lane b;
        logic signed [CordW-1:0] xs;
        logic signed [CordW-1:0] ys;
        xs = a.x >>> i;
        ys = a.y >>> i;
        if (a.y >= 0) begin
            b.x = a.x + ys;
            b.y = a.y - xs;
            b.z = a.z + atan_ang(i);
        end else begin
            b.x = a.x - ys;
            b.y = a.y + xs;
            b.z = a.z - atan_ang(i);
        end
        return b;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [AngW-1:0] z);
        logic signed [AngW:0] t_sum;
        logic signed [18:0]   t_r;
        t_sum = {z[AngW-1], z} + 35'sd32768;
        t_r   = 19'(t_sum >>> 16);
        if (t_r > 19'sd32767)  return 16'sh7fff;
        if (t_r < -19'sd32768) return 16'sh8000;
        return t_r[15:0];
    endfunction

    localparam int NS = CordicSteps + 1;

    t_cstage w_st [NS];
    logic    w_v  [NS];
    logic    w_adv[NS+1];

    // ---- stage 0: load operands, prescale, pre-rotate into the right half
    logic signed [CordW-1:0] w_ey, w_ex, w_ay, w_ax;
    t_cstage n_p, r_p;
    logic    r_pv;

    assign w_ey = CordW'(i_vec.dz);
    assign w_ex = CordW'(signed'({1'b0, i_hyp}));
    assign w_ay = i_plane ? CordW'(i_vec.dy) : CordW'(i_vec.dx);
    assign w_ax = i_plane ? CordW'(i_vec.dx) : CordW'(i_vec.dz);

    always_comb begin
        n_p.ln[0]   = prerot(w_ey, w_ex);
        n_p.ln[1]   = prerot(w_ay, w_ax);
        n_p.zero[0] = (w_ey == 0) && (w_ex == 0);
        n_p.zero[1] = (w_ay == 0) && (w_ax == 0);
        n_p.last    = i_vec.last;
    end

    assign w_adv[0] = !r_pv || w_adv[1];
    assign o_ready  = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_adv[0]) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) r_p <= n_p;
    end

    assign w_st[0] = r_p;
    assign w_v[0]  = r_pv;

    // ---- micro-rotation stages
    for (genvar k = 1; k < NS; k++) begin : g_step
        t_cstage r_st;
        t_cstage n_st;
        logic    r_v;

        always_comb begin
            n_st = w_st[k-1];
            for (int l = 0; l < 2; l++) begin
                n_st.ln[l] = cstep(w_st[k-1].ln[l], k - 1);
            end
        end

        assign w_adv[k] = !r_v || w_adv[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_adv[k]) begin
                r_v <= w_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) r_st <= n_st;
        end

        assign w_st[k] = r_st;
        assign w_v[k]  = r_v;
    end

    // ---- output stage: round, saturate, clamp elevation to a quarter turn
    t_out_beat n_out, r_out;
    logic      r_ov;

    always_comb begin
        logic signed [15:0] t_el;
        t_el = sat16(w_st[NS-1].ln[0].z);
        if (t_el > 16'sd16384)  t_el = 16'sd16384;
        if (t_el < -16'sd16384) t_el = -16'sd16384;
        n_out.elevation = w_st[NS-1].zero[0] ? '0 : t_el;
        n_out.azimuth   = w_st[NS-1].zero[1] ? '0 : sat16(w_st[NS-1].ln[1].z);
        n_out.last_out  = w_st[NS-1].last;
    end

    assign w_adv[NS] = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv[NS]) begin
            r_ov <= w_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NS]) r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_beat  = r_out;

endmodule

// ===== dv/target_azimuth_elevation_tb.sv =====
// ----------------------------------------------------------------------------
// target_azimuth_elevation_tb
// Self-checking bench for the azimuth/elevation pipeline. Target beats are
// sent with random gaps against random back-pressure. The antenna plane is
// changed over the APB port while the pipeline is empty. Each result beat is
// compared field by field with a bit-true model of the square root and the
// CORDIC arctangent.
// ----------------------------------------------------------------------------
module target_azimuth_elevation_tb;
    import tae_pkg::*;

    localparam int          NUM_RANDOM = 550;
    localparam int          QUIET_FROM = 480;   // no idling from this beat on
    localparam int          PHASE_LEN  = 110;   // random beats per plane setting
    localparam int          DRAIN_WAIT = 50;    // margin beyond the pipeline depth
    localparam int          STALL_LIMIT = 2000;
    localparam longint      PRESCALE   = 64'sd16777216;
    localparam logic [PaddrW-1:0] ADDR_PLANE = 0;
    localparam logic [PaddrW-1:0] ADDR_NONE  = 4;   // no register here
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_beat          i_in_beat = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_beat         o_out_beat;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PaddrW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    target_azimuth_elevation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Bench state: mirror of plane_mode, angles still owed by the pipeline,
    // and the counters for the summary.
    bit        plane_now = 1'b0;
    t_out_beat angles_due[$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_sent = 0;
    int        n_plane_yz = 0;
    int        n_set_ends = 0;
    bit        quiet = 1'b0;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Floor square root of a 66-bit sum, two bits of radicand per step.
    function automatic longint floor_sqrt66(logic [65:0] s);
        logic [69:0] rem;
        logic [69:0] trial;
        logic [33:0] root;
        rem  = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | 70'(s[2*i +: 2]);
            trial = (70'(root) << 2) | 70'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 34'd1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    // Binary angle of atan2(y, x), pi = 32768, clamped to 16 bits.
    function automatic longint bin_atan2(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        x = x * PRESCALE;
        y = y * PRESCALE;
        // fold the left half-plane onto the right by a quarter turn
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 2 * longint'(AtanTab[0]);
            end else begin
                x = -y;
                y = t;
                z = -2 * longint'(AtanTab[0]);
            end
        end
        for (int i = 0; i < CordicSteps && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(AtanTab[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(AtanTab[i]);
            end
        end
        z = (z + 32768) >>> 16;
        if (z > 32767)  z = 32767;
        if (z < -32768) z = -32768;
        return z;
    endfunction

    function automatic t_out_beat pointing_angles(t_in_beat b, bit yz_plane);
        t_out_beat   r;
        longint      dx, dy, dz, h, el, az;
        logic [63:0] mx, my;
        logic [65:0] sum_sq;
        dx = longint'(b.target_x) - longint'(b.radar_x);
        dy = longint'(b.target_y) - longint'(b.radar_y);
        dz = longint'(b.target_z) - longint'(b.radar_z);
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        sum_sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
        h  = floor_sqrt66(sum_sq);
        el = bin_atan2(dz, h);
        if (el > 16384)  el = 16384;
        if (el < -16384) el = -16384;
        az = yz_plane ? bin_atan2(dy, dx) : bin_atan2(dx, dz);
        r.elevation = el[15:0];
        r.azimuth   = az[15:0];
        r.last_out  = b.last_in_set;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers (all tasks enter and leave on a falling edge)
    // ------------------------------------------------------------------------

    task automatic cfg_write(logic [PaddrW-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_PLANE) begin
            plane_now = data[0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_check_plane();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PLANE;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[0] !== plane_now) begin
            $error("plane_mode read: expected %0d, got %0d", plane_now, prdata[0]);
            n_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid, let the pipeline empty, then allow for its depth.
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (angles_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_plane(bit yz);
        drain_pipe();
        cfg_write(ADDR_NONE, {$urandom} | 32'h1);  // ignored: no such register
        cfg_write(ADDR_PLANE, {31'($urandom_range(0, 32'h7FFF_FFFF)), yz});
        cfg_check_plane();
    endtask

    // Send one beat; owed angles are either given or taken from the model.
    task automatic send_target(t_in_beat b, bit have_el, bit have_az,
                               logic [15:0] el, logic [15:0] az);
        t_out_beat exp_angles;
        int        gap;
        // hold valid low for a random burst now and then
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        exp_angles = pointing_angles(b, plane_now);
        if (have_el) exp_angles.elevation = el;
        if (have_az) exp_angles.azimuth   = az;
        angles_due.push_back(exp_angles);
        n_sent++;
        if (plane_now) n_plane_yz++;
        if (b.last_in_set) n_set_ends++;
        @(negedge i_clk);
    endtask

    function automatic t_in_beat mk_target(logic signed [31:0] rx, ry, rz, tx, ty, tz,
                                           bit last);
        t_in_beat b;
        b.radar_x  = rx;
        b.radar_y  = ry;
        b.radar_z  = rz;
        b.target_x = tx;
        b.target_y = ty;
        b.target_z = tz;
        b.last_in_set = last;
        return b;
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return CMIN;
            1: return CMAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Offset of random magnitude, from a few units up to the full range.
    function automatic logic signed [31:0] rand_offset();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic t_in_beat rand_target();
        t_in_beat b;
        int       kind;
        b = mk_target($urandom, $urandom, $urandom, 0, 0, 0, 1'($urandom_range(0, 1)));
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                b.target_x = $urandom;
                b.target_y = $urandom;
                b.target_z = $urandom;
            end
            1: begin  // target on the radar
                b.target_x = b.radar_x;
                b.target_y = b.radar_y;
                b.target_z = b.radar_z;
            end
            7: begin  // each axis offset or not at random: on an axis, in a plane or anywhere
                b.target_x = b.radar_x + (($urandom_range(0, 1) != 0) ? rand_offset() : 0);
                b.target_y = b.radar_y + (($urandom_range(0, 1) != 0) ? rand_offset() : 0);
                b.target_z = b.radar_z + (($urandom_range(0, 1) != 0) ? rand_offset() : 0);
            end
            8: begin
                b.radar_x  = pick_extreme();
                b.radar_y  = pick_extreme();
                b.radar_z  = pick_extreme();
                b.target_x = pick_extreme();
                b.target_y = pick_extreme();
                b.target_z = pick_extreme();
            end
            default: begin
                b.target_x = b.radar_x + rand_offset();
                b.target_y = b.radar_y + rand_offset();
                b.target_z = b.radar_z + rand_offset();
            end
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: rows marked with known angles carry their own answers
    // ------------------------------------------------------------------------
    typedef struct {
        t_in_beat    beat;
        bit          yz;
        bit          have_el;
        bit          have_az;
        logic [15:0] el;
        logic [15:0] az;
    } t_target_row;

    t_target_row target_rows[$];

    task automatic add_row(t_in_beat b, bit yz, bit have_el, bit have_az,
                           logic [15:0] el, logic [15:0] az);
        t_target_row r;
        r.beat = b;
        r.yz = yz;
        r.have_el = have_el;
        r.have_az = have_az;
        r.el = el;
        r.az = az;
        target_rows.push_back(r);
    endtask

    task automatic build_rows();
        // XY plane
        add_row(mk_target(0, 0, 0, 0, 0, 0, 0), 0, 1, 1, 0, 0);          // zero vector
        add_row(mk_target(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 1), 0, 1, 1, 0, 0);
        add_row(mk_target(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0), 0, 0, 0, 0, 0);
        add_row(mk_target(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1), 0, 0, 0, 0, 0);
        add_row(mk_target(0, 0, 0, 0, 0, 1000, 0), 0, 0, 0, 0, 0);       // overhead
        add_row(mk_target(0, 0, 0, 0, 0, -1000, 0), 0, 0, 0, 0, 0);      // straight down
        add_row(mk_target(0, 0, 0, -1000, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk_target(5, 5, 5, 6, 5, 4, 1), 0, 0, 0, 0, 0);
        add_row(mk_target(CMIN, CMAX, 0, CMAX, CMIN, CMIN, 0), 0, 0, 0, 0, 0);
        add_row(mk_target(-3, -4, -5, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk_target(0, 0, CMIN, 1, 1, CMAX, 1), 0, 0, 0, 0, 0);    // elevation near pi/2
        // YZ plane
        add_row(mk_target(7, 7, 7, 7, 7, 7, 1), 1, 1, 1, 0, 0);          // zero vector
        add_row(mk_target(1000, 0, 0, 0, 0, 0, 0), 1, 0, 1, 0, 16'sd32767); // azimuth pi
        add_row(mk_target(CMAX, 0, 0, CMIN, 0, 0, 0), 1, 0, 1, 0, 16'sd32767);
        add_row(mk_target(0, 0, 0, -5, -1, 0, 0), 1, 0, 0, 0, 0);        // just past -pi
        add_row(mk_target(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1), 1, 0, 0, 0, 0);
        add_row(mk_target(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0), 1, 0, 0, 0, 0);
        add_row(mk_target(0, 0, 0, 0, -1000, 3, 0), 1, 0, 0, 0, 0);
        add_row(mk_target(0, 0, 0, 0, 1, 0, 1), 1, 0, 0, 0, 0);
        add_row(mk_target(-1, CMAX, 0, 0, CMIN, -1, 0), 1, 0, 0, 0, 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver back-pressure in random bursts, none in the closing stretch
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every result beat against the oldest owed angles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (angles_due.size() == 0) begin
                $error("result beat with nothing owed: el %0d az %0d last %0d",
                       o_out_beat.elevation, o_out_beat.azimuth, o_out_beat.last_out);
                n_errors++;
            end else begin
                want = angles_due.pop_front();
                if (o_out_beat.elevation !== want.elevation) begin
                    $error("elevation: expected %0d, got %0d",
                           want.elevation, o_out_beat.elevation);
                    n_errors++;
                end
                if (o_out_beat.azimuth !== want.azimuth) begin
                    $error("azimuth: expected %0d, got %0d",
                           want.azimuth, o_out_beat.azimuth);
                    n_errors++;
                end
                if (o_out_beat.last_out !== want.last_out) begin
                    $error("last_out: expected %0d, got %0d",
                           want.last_out, o_out_beat.last_out);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a beat on either channel ends the run
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        t_in_beat b;
        build_rows();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        cfg_check_plane();   // plane_mode must come out of reset as XY

        // directed rows, switching plane when the table does
        foreach (target_rows[r]) begin
            if (target_rows[r].yz != plane_now) begin
                set_plane(target_rows[r].yz);
            end
            send_target(target_rows[r].beat, target_rows[r].have_el,
                        target_rows[r].have_az, target_rows[r].el, target_rows[r].az);
        end

        // random targets, alternating planes between phases
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                set_plane(((n / PHASE_LEN) % 2) == 0);
            end
            if (n == QUIET_FROM) begin
                quiet = 1'b1;
            end
            b = rand_target();
            send_target(b, 0, 0, 0, 0);
        end

        drain_pipe();
        $display("sent %0d targets (%0d in YZ plane, %0d set ends), checked %0d results",
                 n_sent, n_plane_yz, n_set_ends, n_results);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
